### rtl/core/wsfu_pkg.sv
// Package for the WebSocket frame unmasker: field widths, header constants
// and the result struct passed from the frame FSM to the top level.
// No dependencies.
package wsfu_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned OpcodeW = 4;
  localparam int unsigned LenW    = 7;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned KeyIdxW = 2;
  localparam int unsigned OutDataW = 16;

  localparam logic [LenW-1:0] LenExt16 = 7'd126;
  localparam logic [LenW-1:0] LenExt64 = 7'd127;

  typedef struct packed {
    logic               valid;
    logic [ByteW-1:0]   data;
    logic [OpcodeW-1:0] opcode;
    logic               fin;
    logic               last;
  } wsfu_result_t;

endpackage

### rtl/core/wsfu_frame_fsm.sv
// Frame parser for the WebSocket frame unmasker: header, key and payload
// tracking, plus the XOR that unmasks one payload byte.
// Depends on wsfu_pkg.
module wsfu_frame_fsm (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [wsfu_pkg::ByteW-1:0] byte_i,
  input  logic                       eom_i,
  output wsfu_pkg::wsfu_result_t     result_o
);
  import wsfu_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_KEY0,
    PH_KEY1,
    PH_KEY2,
    PH_KEY3,
    PH_DATA,
    PH_IDLE
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [KeyW-1:0]      key_q, key_d;
  logic [KeyIdxW-1:0]   idx_q, idx_d;
  logic [LenW-1:0]      len_q, len_d;
  logic                 fin_q, fin_d;
  logic [OpcodeW-1:0]   opc_q, opc_d;

  logic [LenW-1:0]      hdr_len;
  logic [ByteW-1:0]     key_byte;

  assign hdr_len  = byte_i[LenW-1:0];
  // first key byte sits in the top bits
  assign key_byte = key_q[KeyW-1 - ByteW*idx_q -: ByteW];

  always_comb begin
    phase_d  = phase_q;
    key_d    = key_q;
    idx_d    = idx_q;
    len_d    = len_q;
    fin_d    = fin_q;
    opc_d    = opc_q;
    result_o = '0;
    result_o.data   = byte_i ^ key_byte;
    result_o.opcode = opc_q;
    result_o.fin    = fin_q;
    result_o.last   = 1'b0;
    if (accept_i) begin
      unique case (phase_q)
        PH_HDR0: begin
          fin_d   = byte_i[ByteW-1];
          opc_d   = byte_i[OpcodeW-1:0];
          phase_d = PH_HDR1;
        end
        PH_HDR1: begin
          if (byte_i[ByteW-1] && hdr_len != LenExt16 && hdr_len != LenExt64) begin
            len_d   = hdr_len;
            idx_d   = '0;
            phase_d = PH_KEY0;
          end else begin
            phase_d = PH_IDLE;
          end
        end
        PH_KEY0, PH_KEY1, PH_KEY2: begin
          key_d   = {key_q[KeyW-ByteW-1:0], byte_i};
          phase_d = phase_e'(phase_q + 3'd1);
        end
        PH_KEY3: begin
          key_d   = {key_q[KeyW-ByteW-1:0], byte_i};
          phase_d = (len_q == '0) ? PH_IDLE : PH_DATA;
        end
        PH_DATA: begin
          result_o.valid = 1'b1;
          result_o.last  = (len_q == LenW'(1));
          idx_d = idx_q + KeyIdxW'(1);
          len_d = len_q - LenW'(1);
          if (len_q == LenW'(1)) begin
            phase_d = PH_IDLE;
          end
        end
        PH_IDLE: begin
        end
        default: begin
          phase_d = PH_HDR0;
        end
      endcase
      if (eom_i) begin
        phase_d = PH_HDR0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR0;
      key_q   <= '0;
      idx_q   <= '0;
      len_q   <= '0;
      fin_q   <= 1'b0;
      opc_q   <= '0;
    end else begin
      phase_q <= phase_d;
      key_q   <= key_d;
      idx_q   <= idx_d;
      len_q   <= len_d;
      fin_q   <= fin_d;
      opc_q   <= opc_d;
    end
  end

  a_data_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> len_q != '0)
    else $error("payload phase with no bytes left");

  a_eom_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && eom_i |=> phase_q == PH_HDR0)
    else $error("end of message did not return to header");

  a_last_only_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.last |-> result_o.valid && phase_q == PH_DATA)
    else $error("last marked without a payload result");

endmodule

### rtl/core/websocket_frame_unmasker_unit.sv
// WebSocket frame unmasker: one byte per item in, unmasked payload bytes out.
// A result is registered; it is on m_axis in the cycle after its item is accepted.
// Throughput: one item per cycle; the single output register is refilled in the
// cycle it drains, so s_axis_tready stalls only while that register is held.
// Reset (rst_ni low, asynchronous) returns to header byte zero, empties output.
// Depends on wsfu_pkg and wsfu_frame_fsm.
module websocket_frame_unmasker_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [wsfu_pkg::ByteW-1:0]    s_axis_tdata,  // [7:0] in_byte
  input  logic                          s_axis_tlast,  // end_of_message
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] out_byte, [11:8] frame_opcode, [12] frame_fin, [15:13] zero
  output logic [wsfu_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                          m_axis_tlast   // last_payload
);
  import wsfu_pkg::*;

  logic         accept;
  wsfu_result_t res;

  logic                out_valid_q, out_valid_d;
  logic [ByteW-1:0]    out_byte_q;
  logic [OpcodeW-1:0]  out_opc_q;
  logic                out_fin_q;
  logic                out_last_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  wsfu_frame_fsm u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .eom_i    (s_axis_tlast),
    .result_o (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (res.valid) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_byte_q <= res.data;
      out_opc_q  <= res.opcode;
      out_fin_q  <= res.fin;
      out_last_q <= res.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - ByteW - OpcodeW - 1)'(0), out_fin_q, out_opc_q,
                          out_byte_q};
  assign m_axis_tlast  = out_last_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |-> !res.valid)
    else $error("result produced while output register is held");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |=> out_valid_q)
    else $error("result lost");

  a_result_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> accept)
    else $error("result without an accepted item");

endmodule

### tb/websocket_frame_unmasker_unit_tb.sv
// Testbench for websocket_frame_unmasker_unit: a short table of hand-built frames, then
// random messages under several idle/stall patterns, checked by table rows or a predictor.
// Depends on wsfu_pkg and the unmasker RTL.
`timescale 1ns / 100ps

module websocket_frame_unmasker_unit_tb;
  import wsfu_pkg::*;

  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned PhaseItems  = 256;
  localparam int unsigned NumPhases   = 4;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned DirN        = 27;

  typedef enum logic [2:0] {
    HDR_FIRST, HDR_LEN, KEY_B0, KEY_B1, KEY_B2, KEY_B3, PAYLOAD, SKIP
  } rx_phase_e;

  // How a table row gets its expected result.
  typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_ONE} row_check_e;

  typedef struct packed {
    logic [ByteW-1:0]   data;
    logic [OpcodeW-1:0] opcode;
    logic               fin;
    logic               last;
  } frame_byte_t;

  typedef struct packed {
    logic [ByteW-1:0]   b;
    logic               eom;
    row_check_e         chk;
    logic [ByteW-1:0]   exp_data;
    logic [OpcodeW-1:0] exp_opc;
    logic               exp_fin;
    logic               exp_last;
  } dir_row_t;

  localparam dir_row_t DirRows [DirN] = '{
    // fin=1 opcode 1, masked len 2, all-zero key, one byte past the length
    '{8'h81, 1'b0, CHK_NONE, 8'h00, 4'h0, 1'b0, 1'b0},
    '{8'h82, 1'b0, CHK_NONE, 8'h00, 4'h0, 1'b0, 1'b0},
    '{8'h00, 1'b0, CHK_NONE, 8'h00, 4'h0, 1'b0, 1'b0},
    '{8'h00, 1'b0, CHK_NONE, 8'h00, 4'h0, 1'b0, 1'b0},
    '{8'h00, 1'b0, CHK_NONE, 8'h00, 4'h0, 1'b0, 1'b0},
    '{8'h00, 1'b0, CHK_NONE, 8'h00, 4'h0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, CHK_ONE,  8'hFF, 4'h1, 1'b1, 1'b0},
    '{8'h00, 1'b0, CHK_ONE,  8'h00, 4'h1, 1'b1, 1'b1},
    '{8'h55, 1'b1, CHK_NONE, 8'h00, 4'h0, 1'b0, 1'b0},
    // fin=0, reserved bits set, zero length: key taken, nothing out
    '{8'h7A, 1'b0, CHK_NONE, 8'h00, 4'h0, 1'b0, 1'b0},
    '{8'h80, 1'b0, CHK_NONE, 8'h00, 4'h0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, CHK_NONE, 8'h00, 4'h0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, CHK_NONE, 8'h00, 4'h0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, CHK_NONE, 8'h00, 4'h0, 1'b0, 1'b0},
    '{8'hFF, 1'b1, CHK_NONE, 8'h00, 4'h0, 1'b0, 1'b0},
    // unmasked frame
    '{8'h02, 1'b0, CHK_NONE, 8'h00, 4'h0, 1'b0, 1'b0},
    '{8'h7E, 1'b1, CHK_NONE, 8'h00, 4'h0, 1'b0, 1'b0},
    // masked, 64-bit extended length
    '{8'h8F, 1'b0, CHK_NONE, 8'h00, 4'h0, 1'b0, 1'b0},
    '{8'hFF, 1'b1, CHK_NONE, 8'h00, 4'h0, 1'b0, 1'b0},
    // len 3 with a real key, message cut after two payload bytes
    '{8'h88, 1'b0, CHK_NONE, 8'h00, 4'h0, 1'b0, 1'b0},
    '{8'h83, 1'b0, CHK_NONE, 8'h00, 4'h0, 1'b0, 1'b0},
    '{8'h12, 1'b0, CHK_NONE, 8'h00, 4'h0, 1'b0, 1'b0},
    '{8'h34, 1'b0, CHK_NONE, 8'h00, 4'h0, 1'b0, 1'b0},
    '{8'h56, 1'b0, CHK_NONE, 8'h00, 4'h0, 1'b0, 1'b0},
    '{8'h78, 1'b0, CHK_NONE, 8'h00, 4'h0, 1'b0, 1'b0},
    '{8'hA5, 1'b0, CHK_PRED, 8'h00, 4'h0, 1'b0, 1'b0},
    '{8'hC3, 1'b1, CHK_PRED, 8'h00, 4'h0, 1'b0, 1'b0}
  };

  localparam int unsigned SrcIdle  [NumPhases] = '{0, 81, 0, 11};
  localparam int unsigned SinkStall[NumPhases] = '{0, 0, 81, 11};

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [ByteW-1:0]    s_axis_tdata;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  websocket_frame_unmasker_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state
  rx_phase_e        rx_phase;
  logic [KeyW-1:0]  rx_key;
  logic [LenW-1:0]  rx_count;
  logic [LenW-1:0]  rx_left;
  logic             rx_fin;
  logic [OpcodeW-1:0] rx_opcode;

  frame_byte_t pending_bytes[$];
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned cycle_cnt;
  int unsigned src_idle;
  int unsigned sink_stall;

  function automatic void unmask_byte(input logic [ByteW-1:0] b, input logic eom,
                                      output logic got, output frame_byte_t r);
    int kb;
    got = 1'b0;
    r   = '0;
    case (rx_phase)
      HDR_FIRST: begin
        rx_fin    = b[7];
        rx_opcode = b[3:0];
        rx_phase  = HDR_LEN;
      end
      HDR_LEN: begin
        if (b[7] && b[6:0] != LenExt16 && b[6:0] != LenExt64) begin
          rx_left  = b[6:0];
          rx_count = '0;
          rx_key   = '0;
          rx_phase = KEY_B0;
        end else begin
          rx_phase = SKIP;
        end
      end
      PAYLOAD: begin
        // first key byte sits in the top byte of the key word
        kb       = 3 - int'(rx_count[1:0]);
        r.data   = b ^ rx_key[8*kb +: 8];
        r.opcode = rx_opcode;
        r.fin    = rx_fin;
        r.last   = (rx_left == 7'd1);
        got      = 1'b1;
        rx_count = rx_count + 7'd1;
        rx_left  = rx_left - 7'd1;
        if (rx_left == '0) rx_phase = SKIP;
      end
      SKIP: ;
      default: begin
        rx_key = {rx_key[KeyW-9:0], b};
        if (rx_phase == KEY_B3) rx_phase = (rx_left == '0) ? SKIP : PAYLOAD;
        else rx_phase = rx_phase_e'(rx_phase + 3'd1);
      end
    endcase
    if (eom) rx_phase = HDR_FIRST;
  endfunction

  // Called right after a rising edge; returns right after the edge that took the item.
  task automatic send_byte(input logic [ByteW-1:0] b, input logic eom,
                           input row_check_e chk, input frame_byte_t typed);
    logic        got;
    frame_byte_t pred;
    while ($urandom_range(0, 99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eom;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    unmask_byte(b, eom, got, pred);
    case (chk)
      CHK_PRED: if (got) pending_bytes.insert(pending_bytes.size(), pred);
      CHK_ONE:  pending_bytes.insert(pending_bytes.size(), typed);
      default: ;
    endcase
  endtask

  // Mostly well-formed masked frames with random content; the rest skipped
  // headers, cut-off frames and short bursts of noise.
  task automatic send_message();
    logic [ByteW-1:0] msg[$];
    int kind;
    int sel;
    int len;
    int cut;
    kind = $urandom_range(0, 99);
    msg.insert(msg.size(), 8'($urandom));
    if (kind < 88 && kind >= 80) begin
      case ($urandom_range(0, 2))
        0:       msg.insert(msg.size(), {1'b0, 7'($urandom)});
        1:       msg.insert(msg.size(), {1'b1, LenExt16});
        default: msg.insert(msg.size(), {1'b1, LenExt64});
      endcase
      repeat ($urandom_range(0, 6)) msg.insert(msg.size(), 8'($urandom));
    end else if (kind < 96) begin
      sel = $urandom_range(0, 99);
      len = (sel < 70) ? $urandom_range(0, 8) :
            (sel < 92) ? $urandom_range(9, 40) : $urandom_range(41, 125);
      msg.insert(msg.size(), {1'b1, 7'(len)});
      repeat (4 + len) msg.insert(msg.size(), 8'($urandom));
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) msg.insert(msg.size(), 8'($urandom));
      end
      if (kind >= 88) begin
        cut = $urandom_range(1, msg.size() - 1);
        while (msg.size() > cut) void'(msg.pop_back());
      end
    end else begin
      repeat ($urandom_range(0, 5)) msg.insert(msg.size(), 8'($urandom));
    end
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1, CHK_PRED, '0);
  endtask

  task automatic report(input string field, input logic [ByteW-1:0] exp_v,
                        input logic [ByteW-1:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s expected %h actual %h", $time, field, exp_v, act_v);
    end
  endtask

  // Output side: check on each accepted item, then pick tready for the next cycle.
  always @(posedge clk_i) begin
    frame_byte_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_bytes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item, expected none actual %h last %b",
                 $time, m_axis_tdata, m_axis_tlast);
      end else begin
        e = pending_bytes.pop_front();
        report("out_byte", e.data, m_axis_tdata[7:0]);
        report("frame_opcode", 8'(e.opcode), 8'(m_axis_tdata[11:8]));
        report("frame_fin", 8'(e.fin), 8'(m_axis_tdata[12]));
        report("tdata pad", 8'h00, 8'(m_axis_tdata[15:13]));
        report("last_payload", 8'(e.last), 8'(m_axis_tlast));
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("websocket_frame_unmasker_unit: mismatch");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    mismatches    = 0;
    items_sent    = 0;
    cycle_cnt     = 0;
    src_idle      = 0;
    sink_stall    = 0;
    rx_phase      = HDR_FIRST;
    rx_key        = '0;
    rx_count      = '0;
    rx_left       = '0;
    rx_fin        = 1'b0;
    rx_opcode     = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirRows[i]) begin
      send_byte(DirRows[i].b, DirRows[i].eom, DirRows[i].chk,
                {DirRows[i].exp_data, DirRows[i].exp_opc, DirRows[i].exp_fin,
                 DirRows[i].exp_last});
    end

    for (int p = 0; p < NumPhases; p++) begin
      src_idle   = SrcIdle[p];
      sink_stall = SinkStall[p];
      while (items_sent < DirN + (p + 1) * PhaseItems) send_message();
    end

    s_axis_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("websocket_frame_unmasker_unit: match");
    end else begin
      $display("websocket_frame_unmasker_unit: mismatch");
    end
    $finish;
  end

endmodule
